[rtl/linear_key_value_table_macros.svh]
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, checked at i_clk, off while i_rst_n is low.
`define LKVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at i_clk, off while i_rst_n is low.
`define LKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lkvt_pkg.sv]
`default_nettype none

package lkvt_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int KEY_W_DEF  = 32;
    localparam int DATA_W_DEF = 32;
    localparam int OP_W       = 2;
    localparam int CAP_W      = 5;
    localparam int CAP_RESET  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic capture;
        logic remove;
        logic add;
    } t_cell_cmd;

endpackage

`default_nettype wire

[rtl/lkvt_cell.sv]
`default_nettype none

module lkvt_cell #(
    parameter int KEY_W    = lkvt_pkg::KEY_W_DEF,
    parameter int DATA_W   = lkvt_pkg::DATA_W_DEF,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire                     i_clk,
    input  wire lkvt_pkg::t_cell_cmd i_cmd,
    input  wire [CNT_W-1:0]         i_count,
    input  wire [KEY_W-1:0]         i_cmp_key_a,
    input  wire [KEY_W-1:0]         i_cmp_key_b,
    input  wire [KEY_W-1:0]         i_wr_key_a,
    input  wire [KEY_W-1:0]         i_wr_key_b,
    input  wire [DATA_W-1:0]        i_wr_value,
    input  wire [KEY_W-1:0]         i_nxt_key_a,
    input  wire [KEY_W-1:0]         i_nxt_key_b,
    input  wire [DATA_W-1:0]        i_nxt_value,
    input  wire                     i_hit,
    input  wire [DATA_W-1:0]        i_value,
    output logic                    o_hit,
    output logic [DATA_W-1:0]       o_value,
    output logic [KEY_W-1:0]        o_key_a,
    output logic [KEY_W-1:0]        o_key_b,
    output logic [DATA_W-1:0]       o_entry_value
);

    logic [KEY_W-1:0]  r_key_a;
    logic [KEY_W-1:0]  r_key_b;
    logic [DATA_W-1:0] r_value;
    logic              r_match;
    logic              live;
    logic              at_fill;

    assign live    = (CNT_W'(CELL_IDX) < i_count);
    assign at_fill = (CNT_W'(CELL_IDX) == i_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match <= live && (r_key_a == i_cmp_key_a) && (r_key_b == i_cmp_key_b);
        end
        if (i_cmd.add && at_fill) begin
            r_key_a <= i_wr_key_a;
            r_key_b <= i_wr_key_b;
            r_value <= i_wr_value;
        end else if (i_cmd.remove && (i_hit || r_match)) begin
            // close the gap: pull the entry of the next cell down
            r_key_a <= i_nxt_key_a;
            r_key_b <= i_nxt_key_b;
            r_value <= i_nxt_value;
        end
    end

    // first match in fill order wins
    assign o_hit         = i_hit || r_match;
    assign o_value       = i_hit ? i_value : (r_match ? r_value : '0);
    assign o_key_a       = r_key_a;
    assign o_key_b       = r_key_b;
    assign o_entry_value = r_value;

endmodule

`default_nettype wire

[rtl/linear_key_value_table.sv]
// Linear key/value table built as a chain of entry cells.
// Command channel: drive i_op, i_key_a, i_key_b, i_value_in with start; the beat
// is taken at a rising edge where start is high and busy is low.
// Ops: add appends at the fill position while the count is below capacity;
// get returns the value of the first matching entry in fill order; remove does
// the same, then every later entry moves down one cell and the count drops.
// Result channel: o_success, o_value_out, o_fill_count are valid for the one
// cycle o_strobe is high; there is no back pressure on results.
// Sequence: the accepting edge registers the key compare in every cell and moves
// to the resolve state; there the first match is resolved along the cell chain,
// the write or shift is applied, and the result registers and o_strobe are
// loaded. busy is high in the resolve state, so no new beat is taken until
// the table is through with the last one.
// Config: i_cfg_we with i_cfg_wdata sets the capacity (values above the depth
// saturate) and empties the table; write only while no beat is in flight.
// Reset: capacity returns to its default, the table is empty, no strobe.
`default_nettype none

module linear_key_value_table #(
    parameter int TABLE_DEPTH    = lkvt_pkg::DEPTH_DEF,
    parameter int KEY_PART_WIDTH = lkvt_pkg::KEY_W_DEF,
    parameter int DATA_WIDTH     = lkvt_pkg::DATA_W_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [lkvt_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  wire                                 start,
    output logic                                busy,
    input  wire [lkvt_pkg::OP_W-1:0]            i_op,
    input  wire [KEY_PART_WIDTH-1:0]            i_key_a,
    input  wire [KEY_PART_WIDTH-1:0]            i_key_b,
    input  wire [DATA_WIDTH-1:0]                i_value_in,
    output logic                                o_strobe,
    output logic                                o_success,
    output logic [DATA_WIDTH-1:0]               o_value_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_fill_count
);

    `include "linear_key_value_table_macros.svh"

    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > lkvt_pkg::CAP_W) ? CNT_W : lkvt_pkg::CAP_W;
    localparam int CAP_RST   = (lkvt_pkg::CAP_RESET > TABLE_DEPTH) ?
                               TABLE_DEPTH : lkvt_pkg::CAP_RESET;

    lkvt_pkg::t_state             r_state;
    lkvt_pkg::t_state             n_state;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [CNT_W-1:0]             r_cap;
    logic [CMP_W-1:0]             wr_ext;
    logic [lkvt_pkg::OP_W-1:0]    r_op;
    logic [KEY_PART_WIDTH-1:0]    r_key_a;
    logic [KEY_PART_WIDTH-1:0]    r_key_b;
    logic [DATA_WIDTH-1:0]        r_value_in;
    logic                         r_strobe;
    logic                         r_success;
    logic [DATA_WIDTH-1:0]        r_value_out;
    logic [CNT_W-1:0]             r_fill_count;
    logic                         n_success;
    logic [DATA_WIDTH-1:0]        n_value_out;
    logic                         accept;
    logic                         has_room;
    lkvt_pkg::t_cell_cmd          cell_cmd;

    logic                         w_hit [TABLE_DEPTH+1];
    logic [DATA_WIDTH-1:0]        w_val [TABLE_DEPTH+1];
    logic [KEY_PART_WIDTH-1:0]    w_ka  [TABLE_DEPTH];
    logic [KEY_PART_WIDTH-1:0]    w_kb  [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0]        w_ev  [TABLE_DEPTH];
    logic [KEY_PART_WIDTH-1:0]    w_nka [TABLE_DEPTH];
    logic [KEY_PART_WIDTH-1:0]    w_nkb [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0]        w_nev [TABLE_DEPTH];

    assign accept   = start && !busy;
    assign has_room = (r_count < r_cap);
    assign wr_ext   = CMP_W'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        busy             = 1'b0;
        cell_cmd.capture = 1'b0;
        cell_cmd.remove  = 1'b0;
        cell_cmd.add     = 1'b0;
        case (r_state)
            lkvt_pkg::ST_IDLE: begin
                cell_cmd.capture = start;
                if (start) begin
                    n_state = lkvt_pkg::ST_RESOLVE;
                end
            end
            lkvt_pkg::ST_RESOLVE: begin
                busy            = 1'b1;
                cell_cmd.remove = (r_op == lkvt_pkg::OP_REMOVE);
                cell_cmd.add    = (r_op == lkvt_pkg::OP_ADD) && has_room;
                n_state         = lkvt_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkvt_pkg::ST_IDLE;
            end
        endcase
    end

    // hold the command beat for the resolve cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_op;
            r_key_a    <= i_key_a;
            r_key_b    <= i_key_b;
            r_value_in <= i_value_in;
        end
    end

    assign w_hit[0] = 1'b0;
    assign w_val[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_nka[g] = w_ka[g];
            assign w_nkb[g] = w_kb[g];
            assign w_nev[g] = w_ev[g];
        end else begin : g_link
            assign w_nka[g] = w_ka[g+1];
            assign w_nkb[g] = w_kb[g+1];
            assign w_nev[g] = w_ev[g+1];
        end

        lkvt_cell #(
            .KEY_W    (KEY_PART_WIDTH),
            .DATA_W   (DATA_WIDTH),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cell_cmd),
            .i_count       (r_count),
            .i_cmp_key_a   (i_key_a),
            .i_cmp_key_b   (i_key_b),
            .i_wr_key_a    (r_key_a),
            .i_wr_key_b    (r_key_b),
            .i_wr_value    (r_value_in),
            .i_nxt_key_a   (w_nka[g]),
            .i_nxt_key_b   (w_nkb[g]),
            .i_nxt_value   (w_nev[g]),
            .i_hit         (w_hit[g]),
            .i_value       (w_val[g]),
            .o_hit         (w_hit[g+1]),
            .o_value       (w_val[g+1]),
            .o_key_a       (w_ka[g]),
            .o_key_b       (w_kb[g]),
            .o_entry_value (w_ev[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_success   = 1'b0;
        n_value_out = '0;
        case (r_op)
            lkvt_pkg::OP_ADD: begin
                n_success = has_room;
                if (has_room) begin
                    n_count = r_count + 1'b1;
                end
            end
            lkvt_pkg::OP_REMOVE: begin
                n_success = w_hit[TABLE_DEPTH];
                if (w_hit[TABLE_DEPTH]) begin
                    n_value_out = w_val[TABLE_DEPTH];
                    n_count     = r_count - 1'b1;
                end
            end
            lkvt_pkg::OP_GET: begin
                n_success = w_hit[TABLE_DEPTH];
                if (w_hit[TABLE_DEPTH]) begin
                    n_value_out = w_val[TABLE_DEPTH];
                end
            end
            default: begin
                n_success = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cap    <= CNT_W'(CAP_RST);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= busy;
            if (busy) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                // saturate to the built depth and drop all entries
                r_count <= '0;
                if (wr_ext > CMP_W'(TABLE_DEPTH)) begin
                    r_cap <= CNT_W'(TABLE_DEPTH);
                end else begin
                    r_cap <= CNT_W'(wr_ext);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_success    <= n_success;
            r_value_out  <= n_value_out;
            r_fill_count <= n_count;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_success    = r_success;
    assign o_value_out  = r_value_out;
    assign o_fill_count = r_fill_count;

    `LKVT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
    `LKVT_ASSERT_NEXT(a_resolve_strobe, busy, o_strobe, "resolve cycle gave no result strobe")
    `LKVT_ASSERT_NOW(a_fail_zero, o_strobe && !o_success, o_value_out == '0,
                     "failed result carries a nonzero value")
    `LKVT_ASSERT_NEXT(a_count_step, busy && !i_cfg_we,
                      (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
                      (r_count + 1'b1 == $past(r_count)),
                      "fill count moved by more than one entry")

endmodule

`default_nettype wire

[bench/linear_key_value_table_tb.sv]
`timescale 1ns / 1ps

module linear_key_value_table_tb;

    localparam int DEPTH          = lkvt_pkg::DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_REPORTS    = 10;
    localparam logic [lkvt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic        success;
        logic [31:0] value;
        logic [4:0]  fill;
    } t_lookup_result;

    typedef struct packed {
        logic [lkvt_pkg::OP_W-1:0] op;
        logic [31:0]     key_a;
        logic [31:0]     key_b;
        logic [31:0]     value;
        logic            typed;
        t_lookup_result  answer;
    } t_directed_row;

    localparam int N_DIRECTED = 17;

    // rows with typed set carry their answer; the others go through the predictor
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{lkvt_pkg::OP_GET,    32'h0,        32'h0,        32'h0,
          1'b1, '{1'b0, 32'h0, 5'd0}},
        '{lkvt_pkg::OP_REMOVE, 32'h0,        32'h0,        32'h0,
          1'b1, '{1'b0, 32'h0, 5'd0}},
        '{OP_UNUSED,           32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b1, '{1'b0, 32'h0, 5'd0}},
        '{lkvt_pkg::OP_ADD,    32'h0,        32'h0,        32'h0,
          1'b1, '{1'b1, 32'h0, 5'd1}},
        '{lkvt_pkg::OP_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b1, '{1'b1, 32'h0, 5'd2}},
        '{lkvt_pkg::OP_ADD,    32'h0,        32'hFFFFFFFF, 32'h5A5A5A5A,
          1'b1, '{1'b1, 32'h0, 5'd3}},
        '{lkvt_pkg::OP_ADD,    32'hFFFFFFFF, 32'h0,        32'hA5A5A5A5,
          1'b1, '{1'b1, 32'h0, 5'd4}},
        '{lkvt_pkg::OP_GET,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,
          1'b1, '{1'b1, 32'hFFFFFFFF, 5'd4}},
        '{lkvt_pkg::OP_GET,    32'hFFFFFFFF, 32'h00000001, 32'h0,
          1'b1, '{1'b0, 32'h0, 5'd4}},
        '{lkvt_pkg::OP_ADD,    32'h0,        32'h0,        32'h12345678,
          1'b1, '{1'b1, 32'h0, 5'd5}},
        '{lkvt_pkg::OP_GET,    32'h0,        32'h0,        32'h0,        1'b0, '0},
        '{lkvt_pkg::OP_REMOVE, 32'h0,        32'h0,        32'h0,        1'b0, '0},
        '{lkvt_pkg::OP_GET,    32'h0,        32'h0,        32'hFFFFFFFF, 1'b0, '0},
        '{lkvt_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1'b0, '0},
        '{OP_UNUSED,           32'h0,        32'h0,        32'h0,        1'b0, '0},
        '{lkvt_pkg::OP_GET,    32'hFFFFFFFF, 32'h0,        32'h0,        1'b0, '0},
        '{lkvt_pkg::OP_REMOVE, 32'h0,        32'hFFFFFFFF, 32'h0,        1'b0, '0}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [lkvt_pkg::CAP_W-1:0]  i_cfg_wdata;
    logic                        start;
    logic                        busy;
    logic [lkvt_pkg::OP_W-1:0]   op_drv;
    logic [31:0]                 key_a_drv;
    logic [31:0]                 key_b_drv;
    logic [31:0]                 value_drv;
    logic                        o_strobe;
    logic                        o_success;
    logic [31:0]                 o_value_out;
    logic [4:0]                  o_fill_count;

    // answer typed into the table for the beat on the bus, if any
    logic              beat_typed;
    t_lookup_result    beat_answer;

    // predictor state
    logic [31:0]       tbl_key_a [DEPTH];
    logic [31:0]       tbl_key_b [DEPTH];
    logic [31:0]       tbl_value [DEPTH];
    int                tbl_held     = 0;
    int                tbl_capacity = lkvt_pkg::CAP_RESET;

    t_lookup_result    pending_lookups [$];
    int                mismatches   = 0;
    int                quiet_cycles = 0;
    int                gap_pct      = 0;

    linear_key_value_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_op         (op_drv),
        .i_key_a      (key_a_drv),
        .i_key_b      (key_b_drv),
        .i_value_in   (value_drv),
        .o_strobe     (o_strobe),
        .o_success    (o_success),
        .o_value_out  (o_value_out),
        .o_fill_count (o_fill_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_lookup_result predict_lookup(logic [lkvt_pkg::OP_W-1:0] op,
                                                      logic [31:0] ka, logic [31:0] kb,
                                                      logic [31:0] val);
        t_lookup_result r;
        int hit;
        r   = '0;
        hit = -1;
        if (op == lkvt_pkg::OP_ADD) begin
            if (tbl_held < tbl_capacity) begin
                tbl_key_a[tbl_held] = ka;
                tbl_key_b[tbl_held] = kb;
                tbl_value[tbl_held] = val;
                tbl_held++;
                r.success = 1'b1;
            end
        end else if (op == lkvt_pkg::OP_REMOVE || op == lkvt_pkg::OP_GET) begin
            for (int i = 0; i < tbl_held; i++) begin
                if (hit < 0 && tbl_key_a[i] == ka && tbl_key_b[i] == kb)
                    hit = i;
            end
            if (hit >= 0) begin
                r.success = 1'b1;
                r.value   = tbl_value[hit];
                if (op == lkvt_pkg::OP_REMOVE) begin
                    // close the gap
                    for (int j = hit; j + 1 < tbl_held; j++) begin
                        tbl_key_a[j] = tbl_key_a[j + 1];
                        tbl_key_b[j] = tbl_key_b[j + 1];
                        tbl_value[j] = tbl_value[j + 1];
                    end
                    tbl_held--;
                end
            end
        end
        r.fill = 5'(tbl_held);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    endtask

    // one block does all bookkeeping so beats and results stay ordered within a step
    always @(posedge i_clk) begin
        t_lookup_result want;
        logic progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                tbl_capacity = (i_cfg_wdata > DEPTH) ? DEPTH : int'(i_cfg_wdata);
                tbl_held     = 0;
            end
            if (start && !busy) begin
                want = predict_lookup(op_drv, key_a_drv, key_b_drv, value_drv);
                pending_lookups.push_back(beat_typed ? beat_answer : want);
                progress = 1'b1;
            end
            if (o_strobe) begin
                progress = 1'b1;
                if (pending_lookups.size() == 0) begin
                    note_mismatch("unexpected result", 32'h0, {31'h0, o_success});
                end else begin
                    want = pending_lookups.pop_front();
                    if (o_success !== want.success)
                        note_mismatch("success", {31'h0, want.success}, {31'h0, o_success});
                    if (o_value_out !== want.value)
                        note_mismatch("value_out", want.value, o_value_out);
                    if (o_fill_count !== want.fill)
                        note_mismatch("fill_count", {27'h0, want.fill}, {27'h0, o_fill_count});
                end
            end
        end
        quiet_cycles = progress ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [lkvt_pkg::OP_W-1:0] op, input logic [31:0] ka,
                             input logic [31:0] kb, input logic [31:0] val,
                             input logic typed, input t_lookup_result answer);
        // keep start low while each roll against the phase's gap probability succeeds
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        op_drv      <= op;
        key_a_drv   <= ka;
        key_b_drv   <= kb;
        value_drv   <= val;
        beat_typed  <= typed;
        beat_answer <= answer;
        do @(posedge i_clk); while (busy);
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain_lookups();
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvt_pkg::CAP_W-1:0] word);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [lkvt_pkg::CAP_W-1:0] cap_word, input int gap,
                             input int beats);
        logic [31:0] pool_a [3];
        logic [31:0] pool_b [3];
        logic [lkvt_pkg::OP_W-1:0] op;
        logic [31:0] ka;
        logic [31:0] kb;
        int roll;
        write_capacity(cap_word);
        gap_pct = gap;
        // a small key pool keeps hits, duplicates and partial matches frequent
        for (int k = 0; k < 3; k++) begin
            pool_a[k] = $urandom;
            pool_b[k] = $urandom;
        end
        repeat (beats) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)       op = OP_UNUSED;
            else if (roll < 45) op = lkvt_pkg::OP_ADD;
            else if (roll < 72) op = lkvt_pkg::OP_REMOVE;
            else                op = lkvt_pkg::OP_GET;
            ka = ($urandom_range(0, 9) == 0) ? $urandom : pool_a[$urandom_range(0, 2)];
            kb = ($urandom_range(0, 9) == 0) ? $urandom : pool_b[$urandom_range(0, 2)];
            send_beat(op, ka, kb, $urandom, 1'b0, '0);
            if ($urandom_range(0, 49) == 0)
                drain_lookups();
        end
        drain_lookups();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        start       <= 1'b0;
        op_drv      <= lkvt_pkg::OP_ADD;
        key_a_drv   <= '0;
        key_b_drv   <= '0;
        value_drv   <= '0;
        beat_typed  <= 1'b0;
        beat_answer <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(directed_rows[i].op, directed_rows[i].key_a, directed_rows[i].key_b,
                      directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].answer);
        drain_lookups();

        run_phase(5'd31, 0,  200);
        run_phase(5'd0,  27, 40);
        run_phase(5'd1,  87, 60);
        run_phase(5'd16, 87, 200);
        run_phase(5'd5,  0,  150);
        run_phase(5'd2,  27, 100);
        run_phase(5'd17, 27, 150);
        run_phase(5'($urandom_range(0, 31)), 0, 100);

        if (pending_lookups.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
